/* rtl/ugqe_pkg.sv */
// Shared types, constants and helper functions of the graph query engine.
// No dependencies; every other file refers to this package by scoped names.
package ugqe_pkg;

    localparam int V_MAX     = 32;
    localparam int V_W       = $clog2(V_MAX);
    localparam int CNT_W     = 6;
    localparam int EDGE_W    = 9;
    localparam int MAX_EDGES = V_MAX * (V_MAX - 1) / 2;
    localparam int KIND_W    = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLIQUE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REACH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PATH   = 3'd4;

    typedef logic [V_MAX-1:0] t_vset;
    typedef logic [V_W-1:0]   t_vidx;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_vidx             first_vertex;
        t_vidx             second_vertex;
        t_vidx             cut_first;
        t_vidx             cut_second;
        t_vset             member_set;
        t_vset             visited_set;
    } t_op;

    typedef struct packed {
        logic              answer;
        t_vset             reach_set;
        logic [EDGE_W-1:0] edges_now;
        logic              status;
    } t_result;

    // One access to the adjacency store: a row read and/or a row write.
    typedef struct packed {
        logic  rd_en;
        t_vidx rd_addr;
        logic  wr_en;
        t_vidx wr_addr;
        t_vset wr_data;
    } t_mem_req;

    function automatic t_vset vbit(input t_vidx v);
        vbit = t_vset'(1) << v;
    endfunction

    // Vertices below min(count, V_MAX) are in use.
    function automatic t_vset valid_mask(input logic [CNT_W-1:0] count);
        if (count >= CNT_W'(V_MAX)) begin
            valid_mask = '1;
        end else begin
            valid_mask = (t_vset'(1) << count[V_W-1:0]) - t_vset'(1);
        end
    endfunction

    function automatic t_vidx lowest_index(input t_vset x);
        t_vidx idx;
        idx = '0;
        for (int i = V_MAX - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = V_W'(i);
            end
        end
        lowest_index = idx;
    endfunction

endpackage

/* rtl/ugqe_adj_store.sv */
// Adjacency row store: one row per vertex, one read and one write port.
// Uses ugqe_pkg; rows never written read as zero through per-row valid bits.
module ugqe_adj_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ugqe_pkg::t_mem_req i_req,
    output ugqe_pkg::t_vset    o_rd_data
);

    ugqe_pkg::t_vset r_mem [ugqe_pkg::V_MAX];
    ugqe_pkg::t_vset r_row_ok;
    ugqe_pkg::t_vset r_rd_data;
    logic            r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_ok[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_row_ok[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

/* rtl/ugqe_ctrl.sv */
// Sequencer of the graph query engine: decodes one operation and drives the
// shared row read-and-combine step. Uses ugqe_pkg and the row store's ports.
module ugqe_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ugqe_pkg::t_op                      i_op,
    input  logic [ugqe_pkg::CNT_W-1:0]         i_vertex_count,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output ugqe_pkg::t_result                  o_res,
    output ugqe_pkg::t_mem_req                 o_req,
    input  ugqe_pkg::t_vset                    i_rd_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RD_A   = 3'd3;
    localparam logic [2:0] S_RD_B   = 3'd4;
    localparam logic [2:0] S_WR_A   = 3'd5;
    localparam logic [2:0] S_WR_B   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]                    r_state, n_state;
    ugqe_pkg::t_op                 r_op, n_op;
    ugqe_pkg::t_vset               r_pend, n_pend;
    ugqe_pkg::t_vset               r_reach, n_reach;
    ugqe_pkg::t_vset               r_row, n_row;
    ugqe_pkg::t_vidx               r_cur, n_cur;
    logic                          r_inflight, n_inflight;
    logic                          r_answer, n_answer;
    logic                          r_status, n_status;
    logic [ugqe_pkg::EDGE_W-1:0]   r_edges, n_edges;

    ugqe_pkg::t_vset mask;
    ugqe_pkg::t_vset issue_bit;
    ugqe_pkg::t_vset need;
    ugqe_pkg::t_vset nbr;
    ugqe_pkg::t_vset fresh;
    ugqe_pkg::t_vidx issue_v;
    logic            a_ok;
    logic            b_ok;
    logic            cut_on;

    assign mask      = ugqe_pkg::valid_mask(i_vertex_count);
    assign a_ok      = {1'b0, r_op.first_vertex} < i_vertex_count;
    assign b_ok      = {1'b0, r_op.second_vertex} < i_vertex_count;
    assign cut_on    = (r_op.kind == ugqe_pkg::KIND_PATH)
                       && (r_op.cut_first != r_op.cut_second);
    assign issue_v   = ugqe_pkg::lowest_index(r_pend);
    assign issue_bit = ugqe_pkg::vbit(issue_v);
    assign need      = r_op.member_set & ~ugqe_pkg::vbit(r_cur);

    // Neighbors of the row in flight, with the excluded edge taken out.
    always_comb begin
        nbr = i_rd_data & mask;
        if (cut_on && r_cur == r_op.cut_first) begin
            nbr = nbr & ~ugqe_pkg::vbit(r_op.cut_second);
        end
        if (cut_on && r_cur == r_op.cut_second) begin
            nbr = nbr & ~ugqe_pkg::vbit(r_op.cut_first);
        end
    end
    assign fresh = nbr & ~r_reach;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_pend     = r_pend;
        n_reach    = r_reach;
        n_row      = r_row;
        n_cur      = r_cur;
        n_inflight = r_inflight;
        n_answer   = r_answer;
        n_status   = r_status;
        n_edges    = r_edges;
        o_req      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_answer   = 1'b0;
                n_status   = 1'b0;
                n_reach    = '0;
                n_pend     = '0;
                n_inflight = 1'b0;
                n_state    = S_FINISH;
                case (r_op.kind)
                    ugqe_pkg::KIND_INSERT, ugqe_pkg::KIND_REMOVE: begin
                        if (!(a_ok && b_ok)) begin
                            n_status = 1'b1;
                        end else if (r_op.first_vertex != r_op.second_vertex) begin
                            n_state = S_RD_A;
                        end
                    end
                    ugqe_pkg::KIND_CLIQUE: begin
                        if ((r_op.member_set & ~mask) != '0) begin
                            n_status = 1'b1;
                        end else begin
                            n_answer = 1'b1;
                            n_pend   = r_op.member_set;
                            n_state  = S_SCAN;
                        end
                    end
                    ugqe_pkg::KIND_REACH: begin
                        if (!a_ok) begin
                            n_status = 1'b1;
                        end else begin
                            n_pend  = ugqe_pkg::vbit(r_op.first_vertex);
                            n_reach = r_op.visited_set | ugqe_pkg::vbit(r_op.first_vertex);
                            n_state = S_SCAN;
                        end
                    end
                    ugqe_pkg::KIND_PATH: begin
                        if (!(a_ok && b_ok)) begin
                            n_status = 1'b1;
                        end else if (r_op.first_vertex == r_op.second_vertex) begin
                            n_answer = 1'b1;
                        end else begin
                            n_pend  = ugqe_pkg::vbit(r_op.first_vertex);
                            n_reach = r_op.visited_set | ugqe_pkg::vbit(r_op.first_vertex);
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                // Each cycle reads the lowest pending row and folds in the
                // row read in the cycle before.
                if (r_pend == '0 && !r_inflight) begin
                    n_state = S_FINISH;
                    if (r_op.kind == ugqe_pkg::KIND_PATH) begin
                        n_answer = r_reach[r_op.second_vertex]
                                   & ~r_op.visited_set[r_op.second_vertex];
                    end
                end else begin
                    n_pend     = r_pend;
                    n_inflight = 1'b0;
                    if (r_pend != '0) begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = issue_v;
                        n_pend        = r_pend & ~issue_bit;
                        n_cur         = issue_v;
                        n_inflight    = 1'b1;
                    end
                    if (r_inflight) begin
                        if (r_op.kind == ugqe_pkg::KIND_CLIQUE) begin
                            if ((i_rd_data & need) != need) begin
                                n_answer = 1'b0;
                            end
                        end else begin
                            n_reach = r_reach | fresh;
                            n_pend  = n_pend | fresh;
                        end
                    end
                end
            end
            S_RD_A: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_op.first_vertex;
                n_state       = S_RD_B;
            end
            S_RD_B: begin
                n_row         = i_rd_data;
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_op.second_vertex;
                n_state       = S_WR_A;
            end
            S_WR_A: begin
                n_state = S_FINISH;
                if (r_op.kind == ugqe_pkg::KIND_INSERT && !r_row[r_op.second_vertex]) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = r_op.first_vertex;
                    o_req.wr_data = r_row | ugqe_pkg::vbit(r_op.second_vertex);
                    n_row         = i_rd_data | ugqe_pkg::vbit(r_op.first_vertex);
                    n_edges       = r_edges + 1'b1;
                    n_answer      = 1'b1;
                    n_state       = S_WR_B;
                end else if (r_op.kind == ugqe_pkg::KIND_REMOVE
                             && r_row[r_op.second_vertex]) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = r_op.first_vertex;
                    o_req.wr_data = r_row & ~ugqe_pkg::vbit(r_op.second_vertex);
                    n_row         = i_rd_data & ~ugqe_pkg::vbit(r_op.first_vertex);
                    n_edges       = r_edges - 1'b1;
                    n_answer      = 1'b1;
                    n_state       = S_WR_B;
                end
            end
            S_WR_B: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_op.second_vertex;
                o_req.wr_data = r_row;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_edges    <= '0;
            r_inflight <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_edges    <= n_edges;
            r_inflight <= n_inflight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pend   <= n_pend;
        r_reach  <= n_reach;
        r_row    <= n_row;
        r_cur    <= n_cur;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_FINISH);
    assign o_res.answer    = r_answer;
    assign o_res.reach_set = (r_op.kind == ugqe_pkg::KIND_REACH) ? r_reach : '0;
    assign o_res.edges_now = r_edges;
    assign o_res.status    = r_status;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word did not enter decode");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.wr_en |-> (r_state == S_WR_A || r_state == S_WR_B))
        else $error("row write outside an edge update");

    a_pend_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_op.kind != ugqe_pkg::KIND_CLIQUE)
        |-> ((r_pend & ~r_reach) == '0))
        else $error("pending vertex not marked reached");

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges <= ugqe_pkg::EDGE_W'(ugqe_pkg::MAX_EDGES))
        else $error("edge count beyond a complete graph");

endmodule

/* rtl/undirected_graph_query_engine_unit.sv */
// Channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------
// op        | in        | i_valid / o_ready          | i_kind .. i_visited_set
// result    | out       | o_valid / i_ready          | o_answer, o_reach_set, ...
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_vertex_count
//
// Insert and remove read both rows, then write both back only when the edge changes; a self
// loop or a range error goes straight to the result. A clique test reads one row per member,
// and a walk reads the row of each new vertex it reaches; a row read lands in the cycle after
// issue. Reset clears the row valid bits at once, so the graph is empty.
// A new word is taken only between operations; a waiting result lets the next one run.
// Depends on ugqe_pkg, ugqe_adj_store and ugqe_ctrl.
module undirected_graph_query_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ugqe_pkg::KIND_W-1:0]     i_kind,
    input  logic [ugqe_pkg::V_W-1:0]        i_first_vertex,
    input  logic [ugqe_pkg::V_W-1:0]        i_second_vertex,
    input  logic [ugqe_pkg::V_W-1:0]        i_cut_first,
    input  logic [ugqe_pkg::V_W-1:0]        i_cut_second,
    input  logic [ugqe_pkg::V_MAX-1:0]      i_member_set,
    input  logic [ugqe_pkg::V_MAX-1:0]      i_visited_set,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_answer,
    output logic [ugqe_pkg::V_MAX-1:0]      o_reach_set,
    output logic [ugqe_pkg::EDGE_W-1:0]     o_edges_now,
    output logic                            o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ugqe_pkg::CNT_W-1:0]      i_cfg_vertex_count
);

    logic [ugqe_pkg::CNT_W-1:0] r_vertex_count;
    logic                       r_out_valid;
    ugqe_pkg::t_result          r_out;
    ugqe_pkg::t_op              op;
    ugqe_pkg::t_result          res;
    ugqe_pkg::t_mem_req         req;
    ugqe_pkg::t_vset            rd_data;
    logic                       res_valid;
    logic                       res_ready;

    assign op.kind          = i_kind;
    assign op.first_vertex  = i_first_vertex;
    assign op.second_vertex = i_second_vertex;
    assign op.cut_first     = i_cut_first;
    assign op.cut_second    = i_cut_second;
    assign op.member_set    = i_member_set;
    assign op.visited_set   = i_visited_set;

    assign res_ready = !r_out_valid || i_ready;

    ugqe_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .o_in_ready     (o_ready),
        .i_op           (op),
        .i_vertex_count (r_vertex_count),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_req          (req),
        .i_rd_data      (rd_data)
    );

    ugqe_adj_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= ugqe_pkg::CNT_W'(ugqe_pkg::V_MAX);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vertex_count <= i_cfg_vertex_count;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_answer    = r_out.answer;
    assign o_reach_set = r_out.reach_set;
    assign o_edges_now = r_out.edges_now;
    assign o_status    = r_out.status;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for undirected_graph_query_engine_unit: a directed table, then
// random phases at several vertex counts; each result is checked against the table's value
// or an in-bench graph model. Depends on ugqe_pkg and the RTL of the unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ugqe_pkg::KIND_W-1:0] KIND_RSVD5 = 3'd5;
    localparam logic [ugqe_pkg::KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [ugqe_pkg::KIND_W-1:0] KIND_RSVD7 = 3'd7;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    localparam int PHASE_ITEMS  = 75;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;
    localparam int END_DRAIN    = 2 * ugqe_pkg::V_MAX + 8;
    localparam int STALL_LIMIT  = 3000;

    typedef enum logic [1:0] {ROW_PRED, ROW_WANT, ROW_CFG} t_row_tag;

    typedef struct {
        t_row_tag                   tag;
        logic [ugqe_pkg::CNT_W-1:0] count;
        ugqe_pkg::t_op              op;
        ugqe_pkg::t_result          want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [ugqe_pkg::KIND_W-1:0] i_kind = '0;
    logic [ugqe_pkg::V_W-1:0] i_first_vertex = '0;
    logic [ugqe_pkg::V_W-1:0] i_second_vertex = '0;
    logic [ugqe_pkg::V_W-1:0] i_cut_first = '0;
    logic [ugqe_pkg::V_W-1:0] i_cut_second = '0;
    logic [ugqe_pkg::V_MAX-1:0] i_member_set = '0;
    logic [ugqe_pkg::V_MAX-1:0] i_visited_set = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_answer;
    logic [ugqe_pkg::V_MAX-1:0] o_reach_set;
    logic [ugqe_pkg::EDGE_W-1:0] o_edges_now;
    logic o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ugqe_pkg::CNT_W-1:0] i_cfg_vertex_count = '0;

    // Graph model: adjacency rows, edge count and the vertex count register.
    ugqe_pkg::t_vset adj_rows [ugqe_pkg::V_MAX] = '{default: '0};
    logic [ugqe_pkg::EDGE_W-1:0] graph_edges = '0;
    logic [ugqe_pkg::CNT_W-1:0] vcount_now = ugqe_pkg::CNT_W'(32);

    ugqe_pkg::t_result pending_results[$];
    ugqe_pkg::t_result head;
    t_row rows[$];
    int phase_counts[$] = '{32, 1, 0, 2, 5, 63, 8, 17, 31, 33, 3, 32};
    int mismatches = 0;
    int stall_cycles = 0;
    bit hold_request = 1'b0;
    logic [31:0] rx_cycle = '0;

    undirected_graph_query_engine_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_first_vertex     (i_first_vertex),
        .i_second_vertex    (i_second_vertex),
        .i_cut_first        (i_cut_first),
        .i_cut_second       (i_cut_second),
        .i_member_set       (i_member_set),
        .i_visited_set      (i_visited_set),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_answer           (o_answer),
        .o_reach_set        (o_reach_set),
        .o_edges_now        (o_edges_now),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic int usable_count();
        return (vcount_now > ugqe_pkg::CNT_W'(ugqe_pkg::V_MAX)) ? ugqe_pkg::V_MAX
                                                               : int'(vcount_now);
    endfunction

    function automatic ugqe_pkg::t_vset usable_mask();
        return ugqe_pkg::t_vset'((64'd1 << usable_count()) - 64'd1);
    endfunction

    // Frontier expansion over usable vertices; the cut edge is skipped when cut_on is set.
    function automatic ugqe_pkg::t_vset walk_from(input ugqe_pkg::t_vidx start,
                                                  input ugqe_pkg::t_vset seen,
                                                  input ugqe_pkg::t_vset mask,
                                                  input logic cut_on,
                                                  input ugqe_pkg::t_vidx ca,
                                                  input ugqe_pkg::t_vidx cb);
        ugqe_pkg::t_vset frontier, reach, nxt, row;
        frontier = ugqe_pkg::t_vset'(1) << start;
        reach = seen | frontier;
        while (frontier != '0) begin
            nxt = '0;
            for (int v = 0; v < ugqe_pkg::V_MAX; v++) begin
                if (frontier[v]) begin
                    row = adj_rows[v] & mask;
                    if (cut_on) begin
                        if (v == int'(ca)) row[cb] = 1'b0;
                        if (v == int'(cb)) row[ca] = 1'b0;
                    end
                    nxt |= row;
                end
            end
            nxt &= ~reach;
            reach |= nxt;
            frontier = nxt;
        end
        return reach;
    endfunction

    // Applies one operation to the graph model and returns the word it should produce.
    function automatic ugqe_pkg::t_result predict_op(input ugqe_pkg::t_op op);
        ugqe_pkg::t_result r;
        ugqe_pkg::t_vset mask, need, seen, fresh;
        ugqe_pkg::t_vidx a, b;
        mask = usable_mask();
        a = op.first_vertex;
        b = op.second_vertex;
        r = '0;
        case (op.kind)
            ugqe_pkg::KIND_INSERT, ugqe_pkg::KIND_REMOVE: begin
                if (!mask[a] || !mask[b]) begin
                    r.status = ST_RANGE;
                end else if (a != b) begin
                    if (op.kind == ugqe_pkg::KIND_INSERT && !adj_rows[a][b]) begin
                        adj_rows[a][b] = 1'b1;
                        adj_rows[b][a] = 1'b1;
                        graph_edges++;
                        r.answer = 1'b1;
                    end else if (op.kind == ugqe_pkg::KIND_REMOVE && adj_rows[a][b]) begin
                        adj_rows[a][b] = 1'b0;
                        adj_rows[b][a] = 1'b0;
                        graph_edges--;
                        r.answer = 1'b1;
                    end
                end
            end
            ugqe_pkg::KIND_CLIQUE: begin
                if ((op.member_set & ~mask) != '0) begin
                    r.status = ST_RANGE;
                end else begin
                    r.answer = 1'b1;
                    for (int v = 0; v < ugqe_pkg::V_MAX; v++) begin
                        need = op.member_set & ~(ugqe_pkg::t_vset'(1) << v);
                        if (op.member_set[v] && (adj_rows[v] & need) != need) r.answer = 1'b0;
                    end
                end
            end
            ugqe_pkg::KIND_REACH: begin
                if (!mask[a]) r.status = ST_RANGE;
                else r.reach_set = walk_from(a, op.visited_set, mask, 1'b0, '0, '0);
            end
            ugqe_pkg::KIND_PATH: begin
                if (!mask[a] || !mask[b]) begin
                    r.status = ST_RANGE;
                end else if (a == b) begin
                    r.answer = 1'b1;
                end else begin
                    // A pre-visited origin still starts the walk.
                    seen = op.visited_set & ~(ugqe_pkg::t_vset'(1) << a);
                    fresh = walk_from(a, seen, mask, op.cut_first != op.cut_second,
                                      op.cut_first, op.cut_second) & ~seen;
                    r.answer = fresh[b];
                end
            end
            default: ;
        endcase
        r.edges_now = graph_edges;
        return r;
    endfunction

    function automatic ugqe_pkg::t_vidx pick_bit(input ugqe_pkg::t_vset s);
        ugqe_pkg::t_vidx idx;
        int start;
        idx = '0;
        start = $urandom_range(0, ugqe_pkg::V_MAX - 1);
        for (int i = 0; i < ugqe_pkg::V_MAX; i++) begin
            if (s[(start + i) % ugqe_pkg::V_MAX])
                idx = ugqe_pkg::t_vidx'((start + i) % ugqe_pkg::V_MAX);
        end
        return idx;
    endfunction

    function automatic ugqe_pkg::t_vidx pick_vertex(input int n);
        if (n > 0 && $urandom_range(0, 99) < 85)
            return ugqe_pkg::t_vidx'($urandom_range(0, n - 1));
        return ugqe_pkg::t_vidx'($urandom_range(0, ugqe_pkg::V_MAX - 1));
    endfunction

    function automatic ugqe_pkg::t_op random_op();
        ugqe_pkg::t_op op;
        ugqe_pkg::t_vset mask, nb, set;
        int n, r, v, u, start;
        mask = usable_mask();
        n = usable_count();
        r = $urandom_range(0, 99);
        if (r < 38) op.kind = ugqe_pkg::KIND_INSERT;
        else if (r < 50) op.kind = ugqe_pkg::KIND_REMOVE;
        else if (r < 64) op.kind = ugqe_pkg::KIND_CLIQUE;
        else if (r < 78) op.kind = ugqe_pkg::KIND_REACH;
        else if (r < 95) op.kind = ugqe_pkg::KIND_PATH;
        else op.kind = ugqe_pkg::KIND_W'($urandom_range(KIND_RSVD5, KIND_RSVD7));
        op.first_vertex = pick_vertex(n);
        op.second_vertex = pick_vertex(n);
        op.cut_first = ugqe_pkg::t_vidx'($urandom_range(0, ugqe_pkg::V_MAX - 1));
        op.cut_second = ugqe_pkg::t_vidx'($urandom_range(0, ugqe_pkg::V_MAX - 1));
        op.member_set = $urandom;
        nb = adj_rows[op.first_vertex] & mask;
        if (op.kind == ugqe_pkg::KIND_REMOVE && nb != '0 && $urandom_range(0, 9) < 7) begin
            op.second_vertex = pick_bit(nb);
        end
        if (op.kind == ugqe_pkg::KIND_PATH && mask[op.first_vertex]) begin
            if (nb != '0 && $urandom_range(0, 1) == 0) begin
                op.cut_first = op.first_vertex;
                op.cut_second = pick_bit(nb);
            end
            set = walk_from(op.first_vertex, '0, mask, 1'b0, '0, '0);
            set[op.first_vertex] = 1'b0;
            if (set != '0 && $urandom_range(0, 1) == 0) op.second_vertex = pick_bit(set);
        end
        if (op.kind == ugqe_pkg::KIND_CLIQUE) begin
            r = $urandom_range(0, 9);
            if (r < 5 && n > 0) begin
                // Grow a true clique greedily, so that the positive answer is common.
                v = $urandom_range(0, n - 1);
                set = ugqe_pkg::t_vset'(1) << v;
                nb = adj_rows[v] & mask;
                start = $urandom_range(0, ugqe_pkg::V_MAX - 1);
                for (int i = 0; i < ugqe_pkg::V_MAX; i++) begin
                    u = (start + i) % ugqe_pkg::V_MAX;
                    if (nb[u] && (adj_rows[u] & set) == set && $urandom_range(0, 3) != 0)
                        set[u] = 1'b1;
                end
                op.member_set = set;
            end else if (r < 8) begin
                op.member_set = $urandom & $urandom & mask;
            end
        end
        r = $urandom_range(0, 9);
        if (r < 5) op.visited_set = '0;
        else if (r < 8) op.visited_set = $urandom & $urandom & $urandom;
        else op.visited_set = $urandom;
        return op;
    endfunction

    function automatic ugqe_pkg::t_result res(input logic ans, input ugqe_pkg::t_vset reach,
                                              input int edges, input logic st);
        ugqe_pkg::t_result r;
        r.answer = ans;
        r.reach_set = reach;
        r.edges_now = ugqe_pkg::EDGE_W'(edges);
        r.status = st;
        return r;
    endfunction

    // For a register row the first number is the vertex count to write.
    function automatic t_row dir_row(input t_row_tag tag,
                                     input logic [ugqe_pkg::KIND_W-1:0] kind,
                                     input int a, input int b, input int ca, input int cb,
                                     input ugqe_pkg::t_vset mem, input ugqe_pkg::t_vset vis,
                                     input ugqe_pkg::t_result want);
        t_row r;
        r.tag = tag;
        r.count = ugqe_pkg::CNT_W'(a);
        r.op.kind = kind;
        r.op.first_vertex = ugqe_pkg::t_vidx'(a);
        r.op.second_vertex = ugqe_pkg::t_vidx'(b);
        r.op.cut_first = ugqe_pkg::t_vidx'(ca);
        r.op.cut_second = ugqe_pkg::t_vidx'(cb);
        r.op.member_set = mem;
        r.op.visited_set = vis;
        r.want = want;
        return r;
    endfunction

    // Offers one word and holds it until accepted; leaves i_valid high.
    task automatic send_op(input ugqe_pkg::t_op op, input bit typed,
                           input ugqe_pkg::t_result want);
        ugqe_pkg::t_result guess;
        i_valid <= 1'b1;
        i_kind <= op.kind;
        i_first_vertex <= op.first_vertex;
        i_second_vertex <= op.second_vertex;
        i_cut_first <= op.cut_first;
        i_cut_second <= op.cut_second;
        i_member_set <= op.member_set;
        i_visited_set <= op.visited_set;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        guess = predict_op(op);
        pending_results.push_back(typed ? want : guess);
    endtask

    task automatic write_count(input logic [ugqe_pkg::CNT_W-1:0] value);
        i_cfg_vertex_count <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        vcount_now = value;
    endtask

    task automatic wait_idle(input int extra);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing pending, got %h", $time,
                         {o_answer, o_reach_set, o_edges_now, o_status});
                mismatches++;
            end else begin
                head = pending_results.pop_front();
                if (o_answer !== head.answer)
                    report_field("answer", 32'(head.answer), 32'(o_answer));
                if (o_reach_set !== head.reach_set)
                    report_field("reach_set", head.reach_set, o_reach_set);
                if (o_edges_now !== head.edges_now)
                    report_field("edges_now", 32'(head.edges_now), 32'(o_edges_now));
                if (o_status !== head.status)
                    report_field("status", 32'(head.status), 32'(o_status));
            end
        end
    end

    // Receiver: a stall pattern that rotates through four modes, plus long hold-offs on request.
    always begin
        @(posedge i_clk);
        rx_cycle++;
        if (hold_request) begin
            hold_request = 1'b0;
            i_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge i_clk);
        end else begin
            case (rx_cycle[9:8])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= 1'($urandom_range(0, 1));
                2'd2: i_ready <= (rx_cycle[1:0] == 2'd0);
                default: i_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : main_seq
        int sent, burst, gap;
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_REMOVE, 0, 1, 0, 0, '0, '0,
                               res(0, '0, 0, ST_OK)));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_INSERT, 0, 31, 0, 0, '0, '0,
                               res(1, '0, 1, ST_OK)));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_INSERT, 31, 0, 0, 0, '0, '0,
                               res(0, '0, 1, ST_OK)));
        // Self loop is ignored.
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_INSERT, 7, 7, 0, 0, '0, '0,
                               res(0, '0, 1, ST_OK)));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_INSERT, 0, 5, 0, 0, '0, '0, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_INSERT, 5, 31, 0, 0, '0, '0, '0));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_CLIQUE, 0, 0, 0, 0, '0, '0,
                               res(1, '0, 3, ST_OK)));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_CLIQUE, 0, 0, 0, 0,
                               32'h0000_0200, '0, res(1, '0, 3, ST_OK)));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_CLIQUE, 0, 0, 0, 0,
                               32'h8000_0021, '0, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_CLIQUE, 0, 0, 0, 0, '1, '0, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_REACH, 0, 0, 0, 0, '0, '0, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_REACH, 31, 31, 31, 31,
                               '1, '1, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_PATH, 0, 31, 0, 31, '0, '0, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_PATH, 0, 31, 31, 0,
                               '0, 32'h0000_0020, '0));
        // Origin equal to destination holds even when that vertex is pre-visited.
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_PATH, 3, 3, 0, 0, '0, '1,
                               res(1, '0, 3, ST_OK)));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_PATH, 0, 31, 0, 0,
                               '0, 32'h8000_0000, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_PATH, 5, 0, 7, 7,
                               '0, 32'h0000_0020, '0));
        rows.push_back(dir_row(ROW_WANT, KIND_RSVD5, 31, 31, 31, 31, '1, '1,
                               res(0, '0, 3, ST_OK)));
        rows.push_back(dir_row(ROW_WANT, KIND_RSVD6, 31, 31, 31, 31, '1, '1,
                               res(0, '0, 3, ST_OK)));
        rows.push_back(dir_row(ROW_WANT, KIND_RSVD7, 31, 31, 31, 31, '1, '1,
                               res(0, '0, 3, ST_OK)));
        rows.push_back(dir_row(ROW_CFG, ugqe_pkg::KIND_INSERT, 4, 0, 0, 0, '0, '0, '0));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_INSERT, 0, 5, 0, 0, '0, '0,
                               res(0, '0, 3, ST_RANGE)));
        // Edges to vertices above the count stay, but the walk never enters them.
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_REACH, 0, 0, 0, 0,
                               '0, 32'hFFFF_0000, '0));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_CLIQUE, 0, 0, 0, 0,
                               32'h8000_0000, '0, res(0, '0, 3, ST_RANGE)));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_PATH, 31, 0, 0, 0, '0, '0,
                               res(0, '0, 3, ST_RANGE)));
        rows.push_back(dir_row(ROW_CFG, ugqe_pkg::KIND_INSERT, 0, 0, 0, 0, '0, '0, '0));
        rows.push_back(dir_row(ROW_WANT, ugqe_pkg::KIND_REACH, 0, 0, 0, 0, '0, '0,
                               res(0, '0, 3, ST_RANGE)));
        rows.push_back(dir_row(ROW_CFG, ugqe_pkg::KIND_INSERT, 63, 0, 0, 0, '0, '0, '0));
        rows.push_back(dir_row(ROW_PRED, ugqe_pkg::KIND_REMOVE, 31, 0, 0, 0, '0, '0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].tag)
                ROW_CFG: begin
                    wait_idle(SETTLE);
                    write_count(rows[i].count);
                end
                ROW_WANT: send_op(rows[i].op, 1'b1, rows[i].want);
                default: send_op(rows[i].op, 1'b0, '0);
            endcase
        end

        foreach (phase_counts[p]) begin
            wait_idle(SETTLE);
            write_count(ugqe_pkg::CNT_W'(phase_counts[p]));
            // Two phases start with a long receiver hold-off so the input backs up.
            if (p == 2 || p == 8) hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    send_op(random_op(), 1'b0, '0);
                    sent++;
                end
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        wait_idle(END_DRAIN);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ugqe_pkg.sv
rtl/ugqe_adj_store.sv
rtl/ugqe_ctrl.sv
rtl/undirected_graph_query_engine_unit.sv
sim/testbench.sv
